// ----- hw/rtl/lte_pkg.sv -----
// ----------------------------------------------------------------------------
// lte_pkg
// Shared types and constants for the 5x5 Laws texture energy block.
// ----------------------------------------------------------------------------
package lte_pkg;

    localparam int PIX_W    = 8;
    localparam int SIZE_W   = 9;
    localparam int ENERGY_W = 27;
    localparam int KIDX_W   = 4;
    localparam int NKERN    = 9;
    localparam int RESP_W   = 14;   // |response| <= 36*255 = 9180
    localparam int SQ_W     = 27;

    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    // E5 = 0, S5 = 1, W5 = 2; tap weights for tap m
    function automatic logic signed [3:0] vec_coef(input logic [1:0] v, input logic [2:0] m);
        logic signed [3:0] r;
        r = 4'sd0;
        unique case (v)
            2'd0: begin
                unique case (m)
                    3'd0: r = -4'sd1;
                    3'd1: r = -4'sd2;
                    3'd3: r = 4'sd2;
                    3'd4: r = 4'sd1;
                    default: r = 4'sd0;
                endcase
            end
            2'd1: begin
                unique case (m)
                    3'd0: r = -4'sd1;
                    3'd2: r = 4'sd2;
                    3'd4: r = -4'sd1;
                    default: r = 4'sd0;
                endcase
            end
            default: begin
                unique case (m)
                    3'd0: r = -4'sd1;
                    3'd1: r = 4'sd2;
                    3'd3: r = -4'sd2;
                    3'd4: r = 4'sd1;
                    default: r = 4'sd0;
                endcase
            end
        endcase
        return r;
    endfunction

    // controller -> datapath commands
    typedef struct packed {
        logic clear_sums;   // start of window pass
        logic fetch;        // issue memory read for tap (row l, col m)
        logic [2:0] tap_l;
        logic [2:0] tap_m;
        logic fetch_done;   // last tap of the window in flight
        logic div_start;    // start dividing sum[div_k]
        logic [3:0] div_k;
    } lte_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic acc_idle;
    } lte_stat_t;

endpackage

// ----- hw/rtl/lte_stream_if.sv -----
// ----------------------------------------------------------------------------
// lte_stream_if
// Valid/ready stream channel with a parameterized payload.
// ----------------------------------------------------------------------------
interface lte_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/laws_texture_energy.sv -----
// ----------------------------------------------------------------------------
// laws_texture_energy
// 5x5 Laws texture energy over one stored grey image, nine kernel outputs.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  : sink channel, one 8-bit pixel per beat in raster order. Taken
//             one per cycle while loading; ready drops while the stored image
//             is being filtered and while results are delivered.
//   res_out : source channel, nine beats per image {energy, kernel_index,
//             last}, kernel 0..8, last set on the ninth.
//   cfg     : cfg_we/cfg_index/cfg_data write image_rows (0) / image_cols (1).
//             Zero counts as one, values above the maximum saturate.
// Operation: the window pass fetches the 25 taps of each pixel through the
//   single read port of the image memory. Once the pipeline has drained,
//   each of the nine means runs through a bit-serial divider, and each
//   result is held until taken.
// Reset: size registers return to 128, load position to zero. The image
//   memory is not cleared; only written pixels are ever read.
// A stalled receiver simply holds the current result; nothing is lost.
// ----------------------------------------------------------------------------
module laws_texture_energy
    import lte_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    lte_stream_if.sink         pix_in,
    lte_stream_if.source       res_out,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [SIZE_W-1:0]  cfg_data
);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;

    logic [SIZE_W-1:0] rows_reg, cols_reg;
    logic [AW:0]       pos_reg;
    logic [RW:0]       nr;
    logic [CW:0]       nc;
    logic [AW+1:0]     total;
    logic              busy, accept, start;
    lte_cmd_t          cmd;
    lte_stat_t         stat;
    logic [RW:0]       cur_r;
    logic [CW:0]       cur_c;
    logic [KIDX_W-1:0] out_k;
    logic [ENERGY_W-1:0] quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= SIZE_W'(128);
            cols_reg <= SIZE_W'(128);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ROWS) rows_reg <= cfg_data;
            else cols_reg <= cfg_data;
        end
    end

    // effective size: zero -> one, saturate at maximum
    always_comb
    begin
        if (rows_reg == '0) nr = (RW+1)'(1);
        else if (32'(rows_reg) > MAX_ROWS) nr = (RW+1)'(MAX_ROWS);
        else nr = (RW+1)'(rows_reg);
        if (cols_reg == '0) nc = (CW+1)'(1);
        else if (32'(cols_reg) > MAX_COLS) nc = (CW+1)'(MAX_COLS);
        else nc = (CW+1)'(cols_reg);
        total = (AW+2)'(nr * nc);
    end

    assign pix_in.ready = !busy;
    assign accept = pix_in.valid && pix_in.ready;
    assign start = accept && ((AW+2)'(pos_reg) + 1'b1 >= total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) pos_reg <= '0;
        else if (accept) pos_reg <= start ? '0 : pos_reg + 1'b1;
    end

    lte_ctrl #(.RW(RW), .CW(CW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .nr(nr), .nc(nc),
        .stat(stat), .out_ready(res_out.ready), .busy(busy),
        .out_valid(res_out.valid), .out_k(out_k), .cur_r(cur_r),
        .cur_c(cur_c), .cmd(cmd)
    );

    lte_datapath #(.AW(AW), .RW(RW), .CW(CW)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .wr_en(accept && (pos_reg < (AW+1)'(MAX_ROWS*MAX_COLS))),
        .wr_addr(pos_reg[AW-1:0]), .wr_data(pix_in.data),
        .nr(nr), .nc(nc), .cur_r(cur_r), .cur_c(cur_c),
        .total(total), .cmd(cmd), .stat(stat), .quot(quot)
    );

    assign res_out.data = {quot, out_k, out_k == KIDX_W'(NKERN-1)};

    // no pixel is taken while a result is delivered
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> !pix_in.ready) else $error("pixel taken while busy");
    // results are held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |=> res_out.valid && $stable(out_k))
        else $error("result dropped");
    // divider never restarted while running
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy) else $error("divider overrun");
endmodule

// ----- hw/rtl/lte_datapath.sv -----
// ----------------------------------------------------------------------------
// lte_datapath
// Image memory, window tap fetch, response MAC, square-accumulate, divider.
// ----------------------------------------------------------------------------
module lte_datapath
    import lte_pkg::*;
#(
    parameter int AW = 16,
    parameter int RW = 8,
    parameter int CW = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [PIX_W-1:0]    wr_data,
    input  logic [RW:0]         nr,
    input  logic [CW:0]         nc,
    input  logic [RW:0]         cur_r,
    input  logic [CW:0]         cur_c,
    input  logic [RW+CW+1:0]    total,
    input  lte_cmd_t            cmd,
    output lte_stat_t           stat,
    output logic [ENERGY_W-1:0] quot
);
    // energy sums: one squared response per pixel, up to 2^AW pixels
    localparam int SW = SQ_W + AW;

    logic [PIX_W-1:0] mem [0:(1<<AW)-1];
    logic [PIX_W-1:0] rd_data_reg;

    // tap address (clamped)
    logic signed [RW+2:0] rr;
    logic signed [CW+2:0] cc;
    logic [RW:0] rr_c;
    logic [CW:0] cc_c;
    logic [2*(RW+1)+CW:0] addr_full;

    always_comb
    begin
        rr = (RW+3)'($signed({2'b00, cur_r}) + $signed({{RW{1'b0}}, cmd.tap_l}) - 2);
        cc = (CW+3)'($signed({2'b00, cur_c}) + $signed({{CW{1'b0}}, cmd.tap_m}) - 2);
        if (rr < 0) rr_c = '0;
        else if (rr > $signed({2'b00, nr}) - 1) rr_c = nr - 1'b1;
        else rr_c = rr[RW:0];
        if (cc < 0) cc_c = '0;
        else if (cc > $signed({2'b00, nc}) - 1) cc_c = nc - 1'b1;
        else cc_c = cc[CW:0];
        addr_full = rr_c * nc + cc_c;
    end

    logic [AW-1:0] addr_reg;
    logic          addr_v_reg, data_v_reg;
    logic [2:0]    l_s1_reg, m_s1_reg, l_s2_reg, m_s2_reg;
    logic          last_s1_reg, last_s2_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[addr_reg];
        addr_reg <= addr_full[AW-1:0];
        l_s1_reg <= cmd.tap_l; m_s1_reg <= cmd.tap_m;
        l_s2_reg <= l_s1_reg;  m_s2_reg <= m_s1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_v_reg <= 1'b0; data_v_reg <= 1'b0;
            last_s1_reg <= 1'b0; last_s2_reg <= 1'b0;
        end
        else
        begin
            addr_v_reg <= cmd.fetch;  data_v_reg <= addr_v_reg;
            last_s1_reg <= cmd.fetch && cmd.fetch_done;
            last_s2_reg <= last_s1_reg;
        end
    end

    // nine response accumulators: resp_k += a[l]*b[m]*pixel
    logic signed [RESP_W+1:0] resp_reg [NKERN];
    logic signed [RESP_W+1:0] resp_next [NKERN];
    logic [SW-1:0]    sum_reg [NKERN];
    logic             sq_v_reg;
    logic [SQ_W-1:0]  sq_reg [NKERN];
    logic [RESP_W-1:0] mag [NKERN];
    logic signed [7:0] w;

    always_comb
    begin
        for (int k = 0; k < NKERN; k++)
        begin
            w = 8'(vec_coef(2'(k/3), l_s2_reg) * vec_coef(2'(k%3), m_s2_reg));
            resp_next[k] = resp_reg[k]
                + (RESP_W+2)'(w * $signed({1'b0, rd_data_reg}));
            mag[k] = resp_next[k][RESP_W+1] ? RESP_W'(-resp_next[k])
                                            : RESP_W'(resp_next[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= 1'b0;
            for (int k = 0; k < NKERN; k++) resp_reg[k] <= '0;
        end
        else
        begin
            sq_v_reg <= data_v_reg && last_s2_reg;
            if (data_v_reg)
            begin
                for (int k = 0; k < NKERN; k++)
                    resp_reg[k] <= last_s2_reg ? '0 : resp_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_v_reg && last_s2_reg)
        begin
            for (int k = 0; k < NKERN; k++)
                sq_reg[k] <= SQ_W'(mag[k] * mag[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NKERN; k++)
        begin
            if (cmd.clear_sums) sum_reg[k] <= '0;
            else if (sq_v_reg) sum_reg[k] <= sum_reg[k] + SW'(sq_reg[k]);
        end
    end

    // restoring divider, one quotient bit per cycle
    localparam int DW = RW + CW + 2;
    logic [SW-1:0]    dq_reg;
    logic [DW:0]      rem_reg;
    logic [5:0]       dcnt_reg;
    logic             dbusy_reg, ddone_reg;
    logic [DW:0]      trial;

    always_comb trial = {rem_reg[DW-1:0], dq_reg[SW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0; ddone_reg <= 1'b0; dcnt_reg <= '0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1; dcnt_reg <= 6'(SW);
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == 6'd1)
                begin
                    dbusy_reg <= 1'b0; ddone_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg <= sum_reg[cmd.div_k];
            rem_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            if (trial >= {1'b0, total})
            begin
                rem_reg <= trial - {1'b0, total};
                dq_reg  <= {dq_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                dq_reg  <= {dq_reg[SW-2:0], 1'b0};
            end
        end
    end

    assign quot = dq_reg[ENERGY_W-1:0];
    assign stat.div_busy = dbusy_reg;
    assign stat.div_done = ddone_reg;
    assign stat.acc_idle = !addr_v_reg && !data_v_reg && !sq_v_reg;
endmodule

// ----- hw/rtl/lte_ctrl.sv -----
// ----------------------------------------------------------------------------
// lte_ctrl
// Sequencer: waits for a loaded image, then window sweep over taps and pixels, divide and emit.
// ----------------------------------------------------------------------------
module lte_ctrl
    import lte_pkg::*;
#(
    parameter int RW = 8,
    parameter int CW = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RW:0]         nr,
    input  logic [CW:0]         nc,
    input  lte_stat_t           stat,
    input  logic                out_ready,
    output logic                busy,
    output logic                out_valid,
    output logic [KIDX_W-1:0]   out_k,
    output logic [RW:0]         cur_r,
    output logic [CW:0]         cur_c,
    output lte_cmd_t            cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_WAITD = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [RW:0] r_reg, r_next;
    logic [CW:0] c_reg, c_next;
    logic [2:0] l_reg, l_next, m_reg, m_next;
    logic [KIDX_W-1:0] k_reg, k_next;
    logic last_tap;

    always_comb
    begin
        state_next = state_reg;
        r_next = r_reg; c_next = c_reg; l_next = l_reg; m_next = m_reg;
        k_next = k_reg;
        cmd = '0;
        cmd.tap_l = l_reg; cmd.tap_m = m_reg; cmd.div_k = k_reg;
        last_tap = (l_reg == 3'd4) && (m_reg == 3'd4);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.clear_sums = 1'b1;
                    r_next = '0; c_next = '0; l_next = '0; m_next = '0;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cmd.fetch = 1'b1;
                cmd.fetch_done = last_tap;
                if (m_reg == 3'd4)
                begin
                    m_next = '0;
                    l_next = (l_reg == 3'd4) ? 3'd0 : l_reg + 3'd1;
                end
                else m_next = m_reg + 3'd1;
                if (last_tap)
                begin
                    if (c_reg == nc - 1'b1)
                    begin
                        c_next = '0;
                        if (r_reg == nr - 1'b1) state_next = S_DRAIN;
                        else r_next = r_reg + 1'b1;
                    end
                    else c_next = c_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                k_next = '0;
                if (stat.acc_idle) state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = S_WAITD;
            end
            S_WAITD:
            begin
                if (stat.div_done) state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (k_reg == KIDX_W'(NKERN-1)) state_next = S_IDLE;
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            r_reg <= '0; c_reg <= '0; l_reg <= '0; m_reg <= '0; k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg <= r_next; c_reg <= c_next; l_reg <= l_next; m_reg <= m_next;
            k_reg <= k_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_k = k_reg;
    assign cur_r = r_reg;
    assign cur_c = c_reg;
endmodule

// ----- dv/laws_texture_energy_checker.sv -----
// ----------------------------------------------------------------------------
// laws_texture_energy_checker
// Watches the pixel, result and size-register traffic of the Laws texture
// energy block, predicts the nine energies per image and compares each beat.
// ----------------------------------------------------------------------------
module laws_texture_energy_checker
    import lte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lte_stream_if             pix,
    lte_stream_if             res,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    output int                fails,
    output int                pending,
    output int                images
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 256;

    typedef struct {
        logic [ENERGY_W-1:0] energy;
        logic [KIDX_W-1:0]   kidx;
        logic                last;
    } energy_beat_t;

    // E5, S5, W5 tap weights
    const int laws_vec [3][5] = '{'{-1, -2, 0, 2, 1}, '{-1, 0, 2, 0, -1},
                                  '{-1, 2, 0, -2, 1}};

    logic [PIX_W-1:0]  frame [MAX_DIM*MAX_DIM];
    int unsigned       load_count;
    logic [SIZE_W-1:0] rows_reg, cols_reg;
    energy_beat_t      energy_q [$];

    assign pending = energy_q.size();

    function automatic int unsigned dim_of(logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int clamp(int v, int n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    // full window pass over the stored frame, nine means queued in order
    task automatic predict_energies(int nr, int nc);
        longint unsigned sums [9];
        int win [5][5];
        int resp, row_acc;
        energy_beat_t b;
        sums = '{default: 0};
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
            begin
                for (int l = 0; l < 5; l++)
                    for (int m = 0; m < 5; m++)
                        win[l][m] = frame[clamp(r + l - 2, nr) * nc + clamp(c + m - 2, nc)];
                for (int k = 0; k < NKERN; k++)
                begin
                    resp = 0;
                    for (int l = 0; l < 5; l++)
                    begin
                        row_acc = 0;
                        for (int m = 0; m < 5; m++)
                            row_acc += laws_vec[k % 3][m] * win[l][m];
                        resp += laws_vec[k / 3][l] * row_acc;
                    end
                    sums[k] += longint'(resp) * longint'(resp);
                end
            end
        for (int k = 0; k < NKERN; k++)
        begin
            b.energy = ENERGY_W'(sums[k] / longint'(nr * nc));
            b.kidx   = KIDX_W'(k);
            b.last   = (k == NKERN - 1);
            energy_q.push_back(b);
        end
        images++;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        energy_beat_t e;
        logic [ENERGY_W-1:0] got_energy;
        logic [KIDX_W-1:0]   got_kidx;
        logic                got_last;
        int unsigned nr, nc;
        if (!rst_n)
        begin
            load_count = 0;
            rows_reg   = 128;
            cols_reg   = 128;
            energy_q.delete();
            fails      = 0;
            images     = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                {got_energy, got_kidx, got_last} = res.data;
                if (energy_q.size() == 0)
                    report_mismatch("unexpected beat, energy", got_energy, 0);
                else
                begin
                    e = energy_q.pop_front();
                    if (got_kidx != e.kidx)
                        report_mismatch("kernel_index", got_kidx, e.kidx);
                    if (got_energy != e.energy)
                        report_mismatch($sformatf("energy k%0d", e.kidx), got_energy, e.energy);
                    if (got_last != e.last)
                        report_mismatch($sformatf("last k%0d", e.kidx), got_last, e.last);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS)
                    rows_reg = cfg_data;
                else
                    cols_reg = cfg_data;
            end
            if (pix.valid && pix.ready)
            begin
                nr = dim_of(rows_reg);
                nc = dim_of(cols_reg);
                if (load_count < MAX_DIM * MAX_DIM)
                    frame[load_count] = pix.data;
                load_count++;
                if (load_count >= nr * nc)
                begin
                    predict_energies(nr, nc);
                    load_count = 0;
                end
            end
        end
    end

endmodule

// ----- dv/laws_texture_energy_tb.sv -----
// ----------------------------------------------------------------------------
// laws_texture_energy_tb
// Streams grey images of many sizes into the Laws texture energy block and
// checks every energy beat against an independent model in the checker.
// ----------------------------------------------------------------------------
module laws_texture_energy_tb
    import lte_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;  // well above the biggest window pass
    localparam int RANDOM_PIX = 150;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [0:0]        cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    lte_stream_if #(.W(PIX_W))                  pix ();
    lte_stream_if #(.W(ENERGY_W + KIDX_W + 1))  res ();

    int fails, pending, images;

    // stimulus-side bookkeeping
    logic [SIZE_W-1:0] rows_set = 128, cols_set = 128;
    int  pixels_sent;
    int  random_sent;
    bit  calm;          // no idling in the closing stretch
    bit  hold_rx;       // ask the receiver for one long hold-off
    int  idle_cycles;

    always #6 clk = ~clk;

    laws_texture_energy dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix.sink),
        .res_out   (res.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    laws_texture_energy_checker energy_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending),
        .images    (images)
    );

    // Watchdog: cycles with no beat on either channel. Config writes and the
    // pre-write pause are short, so they never get close to the limit.
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d energies outstanding",
                     IDLE_LIMIT, pending);
            $display("laws_texture_energy_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, steady
    // ready once the run goes calm.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                res.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_rx = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    function automatic int unsigned dim_of(logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    // One pixel beat. Entered and left on a falling edge; valid stays high
    // between back-to-back beats.
    task automatic send_pixel(logic [PIX_W-1:0] p);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        pix.valid <= 1'b1;
        pix.data  <= p;
        do
            @(posedge clk);
        while (!pix.ready);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Sender pauses until every energy is back, then lets the divider and
    // pipeline settle before touching a size register.
    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_size(logic [0:0] idx, logic [SIZE_W-1:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_ROWS)
            rows_set = val;
        else
            cols_set = val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // style 0: random, 1: black/white only, 2: ramp
    task automatic send_image(int style);
        int n;
        logic [PIX_W-1:0] p;
        n = dim_of(rows_set) * dim_of(cols_set);
        for (int i = 0; i < n; i++)
        begin
            case (style)
                1:       p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                2:       p = PIX_W'(i * 37);
                default: p = PIX_W'($urandom_range(0, 255));
            endcase
            send_pixel(p);
        end
    endtask

    initial
    begin
        int nr, nc;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_ROWS;
        cfg_data    = '0;
        pix.valid   = 1'b0;
        pix.data    = '0;
        idle_cycles = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed ---
        // zero sizes count as one: a single pixel, flat window
        write_size(REG_ROWS, 0);
        write_size(REG_COLS, 0);
        send_pixel(8'hFF);
        // tiny 2x3 black/white checker
        write_size(REG_ROWS, 2);
        write_size(REG_COLS, 3);
        send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h00);
        send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'hFF);
        // shrinking mid-load: six pixels of a 4x4, then 1x4 -> next pixel closes it
        write_size(REG_ROWS, 4);
        write_size(REG_COLS, 4);
        repeat (6) send_pixel(PIX_W'($urandom_range(0, 255)));
        write_size(REG_ROWS, 1);
        send_pixel(8'h80);

        // --- pressure: long receiver hold while two images are offered ---
        write_size(REG_ROWS, 3);
        write_size(REG_COLS, 3);
        hold_rx = 1'b1;
        send_image(0);
        send_image(2);

        // --- extremes: oversized registers saturate, so a partial load does
        //     not close the image until the size is cut back ---
        write_size(REG_ROWS, 511);
        write_size(REG_COLS, 1);
        repeat (20) send_pixel(PIX_W'($urandom_range(0, 255)));
        write_size(REG_ROWS, 20);
        send_pixel(8'h3C);
        write_size(REG_ROWS, 1);
        write_size(REG_COLS, 300);
        repeat (12) send_pixel(PIX_W'($urandom_range(0, 255)));
        write_size(REG_COLS, 12);
        send_pixel(8'hC3);

        // --- random small images ---
        random_sent = 0;
        while (random_sent < RANDOM_PIX)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                nr = $urandom_range(1, 16);
                nc = $urandom_range(1, 4);
            end
            else
            begin
                nr = $urandom_range(1, 6);
                nc = $urandom_range(1, 6);
            end
            // a zero register behaves as one
            write_size(REG_ROWS, SIZE_W'((nr == 1 && $urandom_range(0, 1)) ? 0 : nr));
            write_size(REG_COLS, SIZE_W'((nc == 1 && $urandom_range(0, 1)) ? 0 : nc));
            nr = pixels_sent;
            send_image($urandom_range(0, 5) == 0 ? 1 : 0);
            random_sent += pixels_sent - nr;
            if (random_sent > RANDOM_PIX * 3 / 4)
                calm = 1'b1;
        end

        wait_drained();
        repeat (60) @(negedge clk);

        $display("covered %0d images from %0d pixels: 1x1 up to 20-row images,",
                 images, pixels_sent);
        $display("  zero/oversized size registers, mid-load shrinks and a 400-cycle result stall");
        if (fails == 0)
            $display("laws_texture_energy_tb OK");
        else
            $display("laws_texture_energy_tb NOT OK");
        $finish;
    end

endmodule
